// ----- rtl/macx_pkg.sv -----
// Shared constants, controller states and control structs for the crossover trend block.
package macx_pkg;

  localparam int SHORT_LEN_DEF  = 3;
  localparam int LONG_LEN_DEF   = 21;
  localparam int PRICE_BITS_DEF = 32;

  localparam int IN_DATA_W  = 32;
  localparam int FIELD_W    = 32;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MULT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic mult;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic full_next;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/moving_average_crossover_trend_top.sv -----
// Top level of the moving-average crossover trend block.
//
//  channel | ports                    | request carries
//  --------+--------------------------+------------------------------------------
//  in      | in_tvalid/tready/tdata   | price [31:0]
//  out     | out_tvalid/tready/tdata  | trend_up [0], current_price [32:1],
//          |                          | target_price [64:33], zero pad [71:65]
//
//  A sample taken while the ring is still filling gives no result.
//  Once full, a sample takes one ring-RAM read per entry through a single compare/accumulate
//  unit, then drain, multiply, load. The next sample is taken while a result waits in the
//  output register; a stalled output holds the block in its final step. Reset is synchronous,
//  active low.
module moving_average_crossover_trend_top
  import macx_pkg::*;
#(
  parameter int SHORT_LEN  = SHORT_LEN_DEF,
  parameter int LONG_LEN   = LONG_LEN_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // price
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // trend_up, current_price, target_price, pad
);

  cmd_t  cmd;
  stat_t stat;

  macx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  macx_dp #(
    .SHORT_LEN  (SHORT_LEN),
    .LONG_LEN   (LONG_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_price   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/macx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module macx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/macx_ctrl.sv -----
// Controller state machine sequencing accept, ring scan, compare and result load.
module macx_ctrl
  import macx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && stat.full_next) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SCAN:  cmd.rd       = 1'b1;
      ST_MULT:  cmd.mult     = 1'b1;
      ST_OUT:   cmd.load_res = stat.out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/macx_dp.sv -----
// Datapath: price ring, running sums, extremes, cross-multiply compare and output register.
module macx_dp
  import macx_pkg::*;
#(
  parameter int SHORT_LEN  = SHORT_LEN_DEF,
  parameter int LONG_LEN   = LONG_LEN_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_DATA_W-1:0]  in_price,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int PW   = (PRICE_BITS < FIELD_W) ? PRICE_BITS : FIELD_W;
  localparam int SE   = (SHORT_LEN < LONG_LEN) ? SHORT_LEN : LONG_LEN;
  localparam int AW   = $clog2(LONG_LEN);
  localparam int FW   = $clog2(LONG_LEN + 1);
  localparam int SSW  = PW + $clog2(SE + 1);
  localparam int LSW  = PW + $clog2(LONG_LEN + 1);
  localparam int PRW  = PW + $clog2(SE + 1) + $clog2(LONG_LEN + 1);
  localparam int PADW = OUT_DATA_W - 1 - 2 * FIELD_W;

  logic [AW-1:0]  slot_r, slot_nxt;
  logic [AW-1:0]  cur_slot_r;
  logic [FW-1:0]  fill_r;
  logic [PW-1:0]  price_r;
  logic [AW-1:0]  rd_addr_r;
  logic [AW-1:0]  rd_idx_r;
  logic           rd_vld_r;
  logic [PW-1:0]  rdata;
  logic [SSW-1:0] ssum_r;
  logic [LSW-1:0] lsum_r;
  logic [PW-1:0]  hi_r, lo_r;
  logic [PRW-1:0] sprod_r, lprod_r;
  logic [AW:0]    age;
  logic           in_short;
  logic           up;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_up_r;
  logic [FIELD_W-1:0]   out_cur_r, out_tgt_r;

  macx_ram #(
    .WIDTH (PW),
    .DEPTH (LONG_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (slot_r),
    .wdata (in_price[PW-1:0]),
    .re    (cmd.rd),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  assign slot_nxt = (slot_r == AW'(LONG_LEN - 1)) ? '0 : slot_r + 1'b1;

  always_comb begin
    if (cur_slot_r >= rd_idx_r) begin
      age = {1'b0, cur_slot_r} - {1'b0, rd_idx_r};
    end else begin
      age = {1'b0, cur_slot_r} + (AW + 1)'(LONG_LEN) - {1'b0, rd_idx_r};
    end
  end

  assign in_short = (age < (AW + 1)'(SE));

  assign stat.full_next = (fill_r >= FW'(LONG_LEN - 1));
  assign stat.rd_last   = (rd_addr_r == AW'(LONG_LEN - 1));
  assign stat.out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.accept) begin
        slot_r <= slot_nxt;
        if (fill_r != FW'(LONG_LEN)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr_r;
    if (cmd.accept) begin
      cur_slot_r <= slot_r;
      price_r    <= in_price[PW-1:0];
      rd_addr_r  <= '0;
      ssum_r     <= '0;
      lsum_r     <= '0;
      hi_r       <= '0;
      lo_r       <= '1;
    end else begin
      if (cmd.rd) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (rd_vld_r) begin
        lsum_r <= lsum_r + LSW'(rdata);
        if (in_short) begin
          ssum_r <= ssum_r + SSW'(rdata);
        end
        if (rdata > hi_r) begin
          hi_r <= rdata;
        end
        if (rdata < lo_r) begin
          lo_r <= rdata;
        end
      end
    end
    if (cmd.mult) begin
      sprod_r <= PRW'(ssum_r) * PRW'(LONG_LEN);
      lprod_r <= PRW'(lsum_r) * PRW'(SE);
    end
  end

  assign up = (sprod_r > lprod_r);

  assign out_tvalid_nxt = cmd.load_res ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_up_r  <= up;
      out_cur_r <= FIELD_W'(price_r);
      out_tgt_r <= up ? FIELD_W'(hi_r) : FIELD_W'(lo_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_tgt_r, out_cur_r, out_up_r};

endmodule

// ----- dv/moving_average_crossover_trend_top_tb.sv -----
// Self-checking testbench for the moving-average crossover trend block.
`timescale 1ns / 1ps

module moving_average_crossover_trend_top_tb;
  import macx_pkg::*;

  localparam int SHORT_N      = SHORT_LEN_DEF;
  localparam int LONG_N       = LONG_LEN_DEF;
  localparam int SHORT_EFF    = (SHORT_N < LONG_N) ? SHORT_N : LONG_N;
  localparam int DRAIN_CYC    = LONG_N + 40;
  localparam int SETTLE_MAX   = 100000;
  localparam int HOLD_CYC     = 400;
  localparam int RAND_PER_PHASE = 530;

  typedef struct packed {
    logic        trend_up;
    logic [31:0] current_price;
    logic [31:0] target_price;
  } trend_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // price
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // trend_up, current_price, target_price, pad

  logic [31:0] price_q[$];
  trend_res_t  trend_q[$];
  logic        in_took = 1'b0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          mismatch_cnt = 0;

  // predictor state
  logic [31:0] win_ring [LONG_N];
  int unsigned win_slot = 0;
  int unsigned win_held = 0;

  moving_average_crossover_trend_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit trend_predict(input logic [31:0] px, output trend_res_t res);
    longint unsigned lsum, ssum, lo, hi, v;
    int unsigned cur, idx;
    bit up;
    res = '0;
    cur = win_slot;
    win_ring[cur] = px;
    win_slot = (cur + 1) % LONG_N;
    if (win_held < LONG_N) win_held++;
    if (win_held < LONG_N) return 1'b0;
    lsum = 0;
    lo = win_ring[0];
    hi = win_ring[0];
    for (int k = 0; k < LONG_N; k++) begin
      v = win_ring[k];
      lsum += v;
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    ssum = 0;
    for (int k = 0; k < SHORT_EFF; k++) begin
      idx = (cur + LONG_N - k) % LONG_N;
      ssum += win_ring[idx];
    end
    up = (ssum * LONG_N) > (lsum * SHORT_EFF);
    res.trend_up      = up;
    res.current_price = px;
    res.target_price  = up ? hi[31:0] : lo[31:0];
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // driver: new request only when the previous one has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (price_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= price_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYC;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: predicts on accepted input, checks accepted results
  always @(posedge clk) begin : mon
    trend_res_t want, got;
    bit emit;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.trend_up      = out_tdata[0];
      got.current_price = out_tdata[32:1];
      got.target_price  = out_tdata[64:33];
      if (out_tdata[71:65] != '0) flag_mismatch("pad", out_tdata[71:65], 0);
      if (trend_q.size() == 0) begin
        flag_mismatch("unexpected result, price", got.current_price, 0);
      end else begin
        want = trend_q.pop_front();
        if (got.trend_up != want.trend_up)
          flag_mismatch("trend_up", got.trend_up, want.trend_up);
        if (got.current_price != want.current_price)
          flag_mismatch("current_price", got.current_price, want.current_price);
        if (got.target_price != want.target_price)
          flag_mismatch("target_price", got.target_price, want.target_price);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      emit = trend_predict(in_tdata, want);
      if (emit) trend_q.insert(trend_q.size(), want);
    end
  end

  // segments of walks, noise, ties and extremes
  task automatic queue_prices(input int n);
    logic [31:0] px;
    int unsigned delta, step;
    int seg, mode;
    bit rising;
    px = $urandom;
    while (n > 0) begin
      seg    = $urandom_range(4, 48);
      mode   = $urandom_range(0, 9);
      rising = $urandom_range(0, 1);
      step   = $urandom_range(1, 1 << $urandom_range(0, 24));
      for (int k = 0; k < seg && n > 0; k++) begin
        case (mode)
          0, 1, 2, 3: begin
            delta = $urandom_range(0, step);
            if (rising ^ ($urandom_range(0, 3) == 0))
              px = (px > 32'hFFFF_FFFF - delta) ? 32'hFFFF_FFFF : px + delta;
            else
              px = (px < delta) ? 32'd0 : px - delta;
          end
          4, 5: px = $urandom;
          6: px = $urandom_range(0, 3);
          7: px = px;
          8: px = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2)
                                       : $urandom_range(0, 2);
          default: px = 32'd1 << $urandom_range(0, 31);
        endcase
        price_q.insert(price_q.size(), px);
        n--;
      end
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while ((price_q.size() != 0 || in_tvalid || trend_q.size() != 0) && waited < SETTLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill with a tie, then a jump to full scale, then zeros
    for (int i = 0; i < LONG_N; i++) price_q.insert(price_q.size(), 32'h8000_0000);
    price_q.insert(price_q.size(), 32'hFFFF_FFFF);
    price_q.insert(price_q.size(), 32'hFFFF_FFFF);
    price_q.insert(price_q.size(), 32'h0000_0000);
    price_q.insert(price_q.size(), 32'h0000_0000);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 0) begin
        snd_idle_pct = 12;
        rcv_idle_pct = 54;
      end else if (phase == 1) begin
        snd_idle_pct = 54;
        rcv_idle_pct = 12;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      queue_prices(RAND_PER_PHASE);
      if (phase != 1) begin
        while (price_q.size() > RAND_PER_PHASE / 2) @(posedge clk);
        hold_token++;
      end
      settle();
    end

    while (trend_q.size() != 0) begin
      flag_mismatch("missing result, price", 0, trend_q[0].current_price);
      void'(trend_q.pop_front());
    end
    if (mismatch_cnt == 0) begin
      $display("moving_average_crossover_trend_top verification clean");
    end else begin
      $display("moving_average_crossover_trend_top verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("moving_average_crossover_trend_top verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/macx_pkg.sv
rtl/macx_ram.sv
rtl/macx_ctrl.sv
rtl/macx_dp.sv
rtl/moving_average_crossover_trend_top.sv
dv/moving_average_crossover_trend_top_tb.sv
